>>> sv/cubic_spline_evaluate_defines.svh
// assertion macros for the cubic spline evaluator
`ifndef CUBIC_SPLINE_EVALUATE_DEFINES_SVH
`define CUBIC_SPLINE_EVALUATE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define CSE_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cubic spline check failed");
// next-cycle implication, checked outside reset
`define CSE_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cubic spline check failed");
`else
`define CSE_CHECK(label, ante, cons)
`define CSE_CHECK_NEXT(label, ante, cons)
`endif

`endif

>>> sv/cse_pkg.sv
// types, constants and saturation helper shared by the cubic spline evaluator
package cse_pkg;

  localparam int MAX_KNOTS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam int KNOT_COUNT_W = 7;
  localparam int ENTRY_W      = 6;
  localparam int SEGMENT_W    = 6;
  localparam int DATA_W       = 32;

  localparam logic [KNOT_COUNT_W-1:0] KNOT_COUNT_RESET = 7'd2;

  // request kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic signed [63:0] S32_MAX_W = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN_W = -64'sd2147483648;

  // one request: table entry write or query
  typedef struct packed {
    logic                     kind;
    logic [ENTRY_W-1:0]       entry_index;
    logic signed [DATA_W-1:0] knot_position;
    logic signed [DATA_W-1:0] coef_const;
    logic signed [DATA_W-1:0] coef_linear;
    logic signed [DATA_W-1:0] coef_square;
    logic signed [DATA_W-1:0] coef_cube;
    logic signed [DATA_W-1:0] query_position;
  } cse_req_t;

  // one result of a query
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] slope;
    logic signed [DATA_W-1:0] bend;
    logic [SEGMENT_W-1:0]     segment;
    logic                     out_of_range;
  } cse_rsp_t;

  // the four coefficients of one segment, one memory word
  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic signed [DATA_W-1:0] d;
  } coef_t;

  // clamp a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > S32_MAX_W) begin
      r = S32_MAX_W[DATA_W-1:0];
    end else if (v < S32_MIN_W) begin
      r = S32_MIN_W[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> sv/cubic_spline_evaluate.sv
// Piecewise cubic spline evaluator: knot/coefficient memories, search and shared multiplier
// Write request: taken in S_IDLE, next request accepted on the following cycle.
// Query: after acceptance, S <= ceil(log2(knots - 1)) search steps (one knot memory read
// each), then six passes through one 32x32 multiplier, before the result is loaded.
// Out-of-range: no search or multiply. Requests stall until a query's result is loaded.
// Synchronous reset clears control and sets knot_count to 2; table contents are kept.
`include "cubic_spline_evaluate_defines.svh"

module cubic_spline_evaluate
  import cse_pkg::*;
#(
  parameter int MAX_KNOTS = MAX_KNOTS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  cse_req_t                req_data,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output cse_rsp_t                rsp_data,
  input  logic                    knot_count_we,
  input  logic [KNOT_COUNT_W-1:0] knot_count_wdata
);

  localparam int IDX_W  = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
  localparam int CNT_W0 = $clog2(MAX_KNOTS + 1);
  localparam int CNT_W  = (CNT_W0 > KNOT_COUNT_W) ? CNT_W0 : KNOT_COUNT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KNOTS);
  localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(2);
  localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LAST, S_RANGE, S_SEARCH, S_PREP, S_MUL, S_DONE
  } state_t;

  // multiply passes, issued in this order
  typedef enum logic [2:0] {
    OP_D  = 3'd0,
    OP_D3 = 3'd1,
    OP_V2 = 3'd2,
    OP_S2 = 3'd3,
    OP_V3 = 3'd4,
    OP_D6 = 3'd5
  } mul_op_t;

  state_t state;
  logic [KNOT_COUNT_W-1:0] knot_count;

  logic signed [DATA_W-1:0] knot_mem [MAX_KNOTS];
  coef_t                    coef_mem [MAX_KNOTS];
  logic signed [DATA_W-1:0] knot_rd;
  coef_t                    coef_rd;

  logic signed [DATA_W-1:0] t_q;
  logic signed [DATA_W-1:0] klo;
  logic [CNT_W-1:0] n_last, lo, hi, mid;

  logic signed [DATA_W-1:0] ca, cb, cc, cd, c2, d3, d6, dx;
  logic signed [DATA_W-1:0] acc_v, acc_s, val_r, slo_r, bnd_r;
  logic                     oor_r;
  logic signed [63:0]       prod_r;
  mul_op_t                  mop, pst_op;
  logic                     iss, pst_on;

  logic req_acc;
  logic wr_en;
  logic [CNT_W-1:0] idx_ext, kc_ext, n_clamp;
  logic [IDX_W-1:0] knot_raddr, coef_raddr;

  logic ge;
  logic [CNT_W-1:0] srch_lo, srch_hi, mid_n;
  logic [CNT_W:0]   mid_sum;
  logic             cont;

  logic signed [32:0]       dx_w;
  logic signed [33:0]       c2_w;
  logic signed [34:0]       d3_w, d6_w;
  logic signed [DATA_W-1:0] opa, addend, fx, post_sum;
  logic signed [63:0]       prod_c, rnd_sum, rnd_sh;
  logic signed [32:0]       sum_w;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign idx_ext   = CNT_W'(req_data.entry_index);
  assign wr_en     = req_acc && (req_data.kind == KIND_WRITE) && (idx_ext < MAX_CNT);

  // knots in use, clamped to the table
  assign kc_ext = CNT_W'(knot_count);
  always_comb begin
    if (kc_ext < MIN_CNT) begin
      n_clamp = MIN_CNT;
    end else if (kc_ext > MAX_CNT) begin
      n_clamp = MAX_CNT;
    end else begin
      n_clamp = kc_ext;
    end
  end

  // binary search step: bracket update and next probe
  assign ge = (t_q >= knot_rd);
  always_comb begin
    if (state == S_RANGE) begin
      srch_lo = '0;
      srch_hi = n_last;
    end else if (ge) begin
      srch_lo = mid;
      srch_hi = hi;
    end else begin
      srch_lo = lo;
      srch_hi = mid;
    end
    mid_sum = {1'b0, srch_lo} + {1'b0, srch_hi};
    mid_n   = mid_sum[CNT_W:1];
    cont    = (srch_hi - srch_lo) > CNT_W'(1);
  end

  // memory read addresses
  always_comb begin
    unique case (state)
      S_LAST:   knot_raddr = n_last[IDX_W-1:0];
      S_RANGE,
      S_SEARCH: knot_raddr = mid_n[IDX_W-1:0];
      default:  knot_raddr = '0;
    endcase
    if (state == S_RANGE || state == S_SEARCH) begin
      coef_raddr = srch_lo[IDX_W-1:0];
    end else begin
      coef_raddr = lo[IDX_W-1:0];
    end
  end

  // knot and coefficient memories
  always_ff @(posedge clk) begin
    if (wr_en) begin
      knot_mem[idx_ext[IDX_W-1:0]] <= req_data.knot_position;
      coef_mem[idx_ext[IDX_W-1:0]] <= '{a: req_data.coef_const, b: req_data.coef_linear,
                                         c: req_data.coef_square, d: req_data.coef_cube};
    end
    knot_rd <= knot_mem[knot_raddr];
    coef_rd <= coef_mem[coef_raddr];
  end

  // offset and scaled coefficients
  always_comb begin
    dx_w = {t_q[DATA_W-1], t_q} - {klo[DATA_W-1], klo};
    c2_w = 34'(coef_rd.c) <<< 1;
    d3_w = (35'(coef_rd.d) <<< 1) + 35'(coef_rd.d);
    d6_w = d3_w <<< 1;
  end

  // multiplier operand for the pass being issued
  always_comb begin
    unique case (mop)
      OP_D:    opa = cd;
      OP_D3:   opa = d3;
      OP_V2:   opa = acc_v;
      OP_S2:   opa = acc_s;
      OP_V3:   opa = acc_v;
      OP_D6:   opa = d6;
      default: opa = cd;
    endcase
    prod_c = opa * dx;
  end

  // round half up, rescale, saturate, then add the pass's term
  always_comb begin
    rnd_sum = prod_r + RND;
    rnd_sh  = rnd_sum >>> FRAC_BITS;
    fx      = sat32(rnd_sh);
    unique case (pst_op)
      OP_D:    addend = cc;
      OP_D3:   addend = c2;
      OP_V2:   addend = cb;
      OP_S2:   addend = cb;
      OP_V3:   addend = ca;
      OP_D6:   addend = c2;
      default: addend = cc;
    endcase
    sum_w    = 33'(addend) + 33'(fx);
    post_sum = sat32(64'(sum_w));
  end

  // sequencer, datapath registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      knot_count <= KNOT_COUNT_RESET;
      rsp_valid  <= 1'b0;
      iss        <= 1'b0;
      pst_on     <= 1'b0;
      mop        <= OP_D;
      pst_op     <= OP_D;
    end else begin
      if (knot_count_we) begin
        knot_count <= knot_count_wdata;
      end
      // result taken and nothing new to load
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_acc && req_data.kind == KIND_QUERY) begin
            t_q    <= req_data.query_position;
            n_last <= n_clamp - CNT_W'(1);
            state  <= S_LAST;
          end
        end
        S_LAST: begin
          klo   <= knot_rd;
          state <= S_RANGE;
        end
        S_RANGE, S_SEARCH: begin
          if (state == S_RANGE && (t_q < klo || t_q > knot_rd)) begin
            // outside the knot range: zero result with flag
            val_r <= '0;
            slo_r <= '0;
            bnd_r <= '0;
            lo    <= '0;
            oor_r <= 1'b1;
            state <= S_DONE;
          end else begin
            if (state == S_SEARCH && ge) begin
              klo <= knot_rd;
            end
            lo    <= srch_lo;
            hi    <= srch_hi;
            mid   <= mid_n;
            oor_r <= 1'b0;
            state <= cont ? S_SEARCH : S_PREP;
          end
        end
        S_PREP: begin
          ca     <= coef_rd.a;
          cb     <= coef_rd.b;
          cc     <= coef_rd.c;
          cd     <= coef_rd.d;
          c2     <= sat32(64'(c2_w));
          d3     <= sat32(64'(d3_w));
          d6     <= sat32(64'(d6_w));
          dx     <= sat32(64'(dx_w));
          mop    <= OP_D;
          iss    <= 1'b1;
          pst_on <= 1'b0;
          state  <= S_MUL;
        end
        S_MUL: begin
          // issue side
          if (iss) begin
            prod_r <= prod_c;
            pst_op <= mop;
            pst_on <= 1'b1;
            if (mop == OP_D6) begin
              iss <= 1'b0;
            end else begin
              mop <= mul_op_t'(mop + 3'd1);
            end
          end else begin
            pst_on <= 1'b0;
          end
          // post side
          if (pst_on) begin
            unique case (pst_op)
              OP_D, OP_V2: acc_v <= post_sum;
              OP_D3:       acc_s <= post_sum;
              OP_S2:       slo_r <= post_sum;
              OP_V3:       val_r <= post_sum;
              OP_D6:       bnd_r <= post_sum;
              default:     acc_v <= post_sum;
            endcase
            if (pst_op == OP_D6) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          pst_on <= 1'b0;
          if (!rsp_valid || !rsp_stall) begin
            rsp_data <= '{value: val_r, slope: slo_r, bend: bnd_r,
                          segment: lo[SEGMENT_W-1:0], out_of_range: oor_r};
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `CSE_CHECK(a_oor_zero, rsp_valid && rsp_data.out_of_range, rsp_data.value == '0 && rsp_data.slope == '0 && rsp_data.bend == '0 && rsp_data.segment == '0)
  `CSE_CHECK(a_search_bracket, state == S_SEARCH, lo < mid && mid < hi)
  `CSE_CHECK(a_post_in_mul, pst_on, state == S_MUL)
  `CSE_CHECK_NEXT(a_query_busy, req_valid && !req_stall && req_data.kind == KIND_QUERY, req_stall)

endmodule
